[hdl/mdds_pkg.sv]
package mdds_pkg;

   // field widths
   localparam int PIXEL_BITS = 8;
   localparam int SHIFT_BITS = 8;
   localparam int PROD_BITS  = 2 * PIXEL_BITS;
   localparam int CORR_BITS  = 28;
   localparam int ERR_BITS   = 20;
   localparam int SCORE_BITS = 20;
   // correlation is divided by 256 before comparison
   localparam int SCALE_SHIFT = 8;

   // one accepted input beat
   typedef struct packed {
      logic [PIXEL_BITS-1:0] left_now;
      logic [PIXEL_BITS-1:0] left_before;
      logic [PIXEL_BITS-1:0] right_now;
      logic [PIXEL_BITS-1:0] right_before;
      logic [SHIFT_BITS-1:0] shift;
      logic                  window_end;
      logic                  search_end;
      logic [SHIFT_BITS-1:0] prior_disparity;
   } mdds_beat_type;

   // per-pixel correlation and error terms
   typedef struct packed {
      logic [PROD_BITS-1:0]  prod;
      logic [PIXEL_BITS-1:0] err;
      logic [SHIFT_BITS-1:0] shift;
      logic                  window_end;
      logic                  search_end;
      logic [SHIFT_BITS-1:0] prior_disparity;
   } mdds_diff_type;

   // totals of one finished shift
   typedef struct packed {
      logic [CORR_BITS-1:0]  corr_total;
      logic [ERR_BITS-1:0]   err_total;
      logic [SHIFT_BITS-1:0] shift;
      logic                  search_end;
      logic [SHIFT_BITS-1:0] prior_disparity;
   } mdds_sums_type;

   // winners at the end of a search
   typedef struct packed {
      logic [SCORE_BITS-1:0] best_corr;
      logic [SHIFT_BITS-1:0] best_corr_shift;
      logic [ERR_BITS-1:0]   best_err;
      logic [SHIFT_BITS-1:0] best_err_shift;
      logic [SHIFT_BITS-1:0] prior_disparity;
   } mdds_win_type;

   function automatic logic [PIXEL_BITS-1:0] abs_diff(input logic [PIXEL_BITS-1:0] a,
                                                      input logic [PIXEL_BITS-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

[hdl/mdds_front.sv]
module mdds_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mdds_pkg::mdds_beat_type in_beat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mdds_pkg::mdds_diff_type out_data
);
   import mdds_pkg::*;

   logic          beat_valid_ff;
   mdds_beat_type beat_ff;
   logic          diff_valid_ff;
   mdds_diff_type diff_ff;
   mdds_diff_type diff_in;
   logic          beat_ready;
   logic          diff_ready;
   logic [PIXEL_BITS-1:0] dl;
   logic [PIXEL_BITS-1:0] dr;

   // stage handshake: a stage moves on when empty or when its beat leaves
   assign diff_ready = !diff_valid_ff || out_ready;
   assign beat_ready = !beat_valid_ff || diff_ready;
   assign in_ready   = beat_ready;

   // temporal differences, their product and their disagreement
   always_comb begin
      dl = abs_diff(beat_ff.left_now, beat_ff.left_before);
      dr = abs_diff(beat_ff.right_now, beat_ff.right_before);
      diff_in.prod            = {{PIXEL_BITS{1'b0}}, dl} * {{PIXEL_BITS{1'b0}}, dr};
      diff_in.err             = abs_diff(dl, dr);
      diff_in.shift           = beat_ff.shift;
      diff_in.window_end      = beat_ff.window_end;
      diff_in.search_end      = beat_ff.search_end;
      diff_in.prior_disparity = beat_ff.prior_disparity;
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
         diff_valid_ff <= 1'b0;
      end else begin
         if (beat_ready) beat_valid_ff <= in_valid;
         if (diff_ready) diff_valid_ff <= beat_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (beat_ready && in_valid) beat_ff <= in_beat;
      if (diff_ready && beat_valid_ff) diff_ff <= diff_in;
   end

   assign out_valid = diff_valid_ff;
   assign out_data  = diff_ff;

endmodule

[hdl/mdds_accum.sv]
module mdds_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mdds_pkg::mdds_diff_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mdds_pkg::mdds_sums_type out_data
);
   import mdds_pkg::*;

   logic [CORR_BITS-1:0] corr_acc_ff;
   logic [ERR_BITS-1:0]  err_acc_ff;
   logic [CORR_BITS-1:0] corr_acc_in;
   logic [ERR_BITS-1:0]  err_acc_in;
   logic [CORR_BITS:0]   corr_wide;
   logic [ERR_BITS:0]    err_wide;
   logic                 sums_valid_ff;
   mdds_sums_type        sums_ff;
   logic                 take;

   assign in_ready = !sums_valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // saturating sums
   always_comb begin
      corr_wide   = {1'b0, corr_acc_ff} + {{(CORR_BITS + 1 - PROD_BITS){1'b0}}, in_data.prod};
      err_wide    = {1'b0, err_acc_ff} + {{(ERR_BITS + 1 - PIXEL_BITS){1'b0}}, in_data.err};
      corr_acc_in = corr_wide[CORR_BITS] ? {CORR_BITS{1'b1}} : corr_wide[CORR_BITS-1:0];
      err_acc_in  = err_wide[ERR_BITS] ? {ERR_BITS{1'b1}} : err_wide[ERR_BITS-1:0];
   end

   // running sums, cleared at the end of each shift
   always_ff @(posedge clock) begin
      if (reset) begin
         corr_acc_ff   <= '0;
         err_acc_ff    <= '0;
         sums_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            if (in_data.window_end) begin
               corr_acc_ff <= '0;
               err_acc_ff  <= '0;
            end else begin
               corr_acc_ff <= corr_acc_in;
               err_acc_ff  <= err_acc_in;
            end
         end
         if (in_ready) sums_valid_ff <= in_valid && in_data.window_end;
      end
   end

   // shift totals
   always_ff @(posedge clock) begin
      if (take && in_data.window_end) begin
         sums_ff.corr_total      <= corr_acc_in;
         sums_ff.err_total       <= err_acc_in;
         sums_ff.shift           <= in_data.shift;
         sums_ff.search_end      <= in_data.search_end;
         sums_ff.prior_disparity <= in_data.prior_disparity;
      end
   end

   assign out_valid = sums_valid_ff;
   assign out_data  = sums_ff;

endmodule

[hdl/mdds_winner.sv]
module mdds_winner (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mdds_pkg::mdds_sums_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mdds_pkg::mdds_win_type  out_data
);
   import mdds_pkg::*;

   logic [SCORE_BITS-1:0] best_corr_ff;
   logic [SHIFT_BITS-1:0] best_corr_shift_ff;
   logic [ERR_BITS-1:0]   best_err_ff;
   logic [SHIFT_BITS-1:0] best_err_shift_ff;
   logic [SCORE_BITS-1:0] best_corr_in;
   logic [SHIFT_BITS-1:0] best_corr_shift_in;
   logic [ERR_BITS-1:0]   best_err_in;
   logic [SHIFT_BITS-1:0] best_err_shift_in;
   logic [SCORE_BITS-1:0] score;
   logic                  win_valid_ff;
   mdds_win_type          win_ff;
   logic                  take;

   assign in_ready = !win_valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // strict compares keep the earlier shift on a tie
   always_comb begin
      score              = in_data.corr_total[CORR_BITS-1:SCALE_SHIFT];
      best_corr_in       = best_corr_ff;
      best_corr_shift_in = best_corr_shift_ff;
      best_err_in        = best_err_ff;
      best_err_shift_in  = best_err_shift_ff;
      if (score > best_corr_ff) begin
         best_corr_in       = score;
         best_corr_shift_in = in_data.shift;
      end
      if (in_data.err_total < best_err_ff) begin
         best_err_in       = in_data.err_total;
         best_err_shift_in = in_data.shift;
      end
   end

   // winners, back to reset values once a search is handed on
   always_ff @(posedge clock) begin
      if (reset) begin
         best_corr_ff       <= '0;
         best_corr_shift_ff <= '0;
         best_err_ff        <= '1;
         best_err_shift_ff  <= '0;
         win_valid_ff       <= 1'b0;
      end else begin
         if (take) begin
            if (in_data.search_end) begin
               best_corr_ff       <= '0;
               best_corr_shift_ff <= '0;
               best_err_ff        <= '1;
               best_err_shift_ff  <= '0;
            end else begin
               best_corr_ff       <= best_corr_in;
               best_corr_shift_ff <= best_corr_shift_in;
               best_err_ff        <= best_err_in;
               best_err_shift_ff  <= best_err_shift_in;
            end
         end
         if (in_ready) win_valid_ff <= in_valid && in_data.search_end;
      end
   end

   // final winners of a search
   always_ff @(posedge clock) begin
      if (take && in_data.search_end) begin
         win_ff.best_corr       <= best_corr_in;
         win_ff.best_corr_shift <= best_corr_shift_in;
         win_ff.best_err        <= best_err_in;
         win_ff.best_err_shift  <= best_err_shift_in;
         win_ff.prior_disparity <= in_data.prior_disparity;
      end
   end

   assign out_valid = win_valid_ff;
   assign out_data  = win_ff;

endmodule

[hdl/motion_diff_disparity_search_unit.sv]
// Disparity search on temporal difference images. Each request beat carries one
// window pixel at one candidate shift; the unit sums, per shift, the product and
// the absolute difference of the left and right frame differences, keeps the
// shift with the greatest correlation/256 and the one with the least error, and
// after the beat that ends both the window and the search returns one response
// beat: whichever winner lies nearer prior_disparity, correlation taking ties.
// One request beat is taken every clock cycle unless rsp_tready back-pressure
// holds it. A five-register pipeline (input, difference/multiply, accumulate,
// winner compare, response) carries the search result to rsp_. Only the response
// register stalls on rsp_tready; the stages ahead of it keep moving until they fill.
module motion_diff_disparity_search_unit (
   input  logic        clock,
   input  logic        reset,
   // request beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // left_now, left_before, right_now, right_before,
                                   // shift, prior_disparity (8 bits each)
   input  logic        req_tlast,  // window_end
   input  logic        req_tuser,  // search_end
   // response beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // disparity (8), best_correlation (20), least_error (20)
);
   import mdds_pkg::*;

   mdds_beat_type req_beat;
   logic          diff_valid;
   logic          diff_ready;
   mdds_diff_type diff_data;
   logic          sums_valid;
   logic          sums_ready;
   mdds_sums_type sums_data;
   logic          win_valid;
   logic          win_ready;
   mdds_win_type  win_data;

   logic                  rsp_valid_ff;
   logic [47:0]           rsp_data_ff;
   logic [SHIFT_BITS-1:0] pick;
   logic [SHIFT_BITS-1:0] dist_corr;
   logic [SHIFT_BITS-1:0] dist_err;

   // unpack request
   always_comb begin
      req_beat.left_now        = req_tdata[7:0];
      req_beat.left_before     = req_tdata[15:8];
      req_beat.right_now       = req_tdata[23:16];
      req_beat.right_before    = req_tdata[31:24];
      req_beat.shift           = req_tdata[39:32];
      req_beat.prior_disparity = req_tdata[47:40];
      req_beat.window_end      = req_tlast;
      req_beat.search_end      = req_tuser;
   end

   mdds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_beat   (req_beat),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .out_data  (diff_data)
   );

   mdds_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .in_data   (diff_data),
      .out_valid (sums_valid),
      .out_ready (sums_ready),
      .out_data  (sums_data)
   );

   mdds_winner u_winner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sums_valid),
      .in_ready  (sums_ready),
      .in_data   (sums_data),
      .out_valid (win_valid),
      .out_ready (win_ready),
      .out_data  (win_data)
   );

   // choose the winner nearer the prior disparity
   always_comb begin
      dist_corr = abs_diff(win_data.prior_disparity, win_data.best_corr_shift);
      dist_err  = abs_diff(win_data.prior_disparity, win_data.best_err_shift);
      pick      = win_data.best_corr_shift;
      if (win_data.best_corr_shift != win_data.best_err_shift && dist_corr > dist_err)
         pick = win_data.best_err_shift;
   end

   assign win_ready = !rsp_valid_ff || rsp_tready;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (win_ready) begin
         rsp_valid_ff <= win_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (win_ready && win_valid) rsp_data_ff <= {win_data.best_err, win_data.best_corr, pick};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
